@@ rtl/lnr_pkg.sv @@
`timescale 1ns / 1ps
package lnr_pkg;

  localparam int DATA_W  = 16;
  localparam int MAX_ROW = 64;
  localparam int ADDR_W  = $clog2(MAX_ROW);
  localparam int CNT_W   = $clog2(MAX_ROW + 1);
  localparam int SUM_W   = DATA_W + CNT_W;
  localparam int DIFF_W  = DATA_W + CNT_W + 1;
  localparam int DMAG_W  = DIFF_W - 1;
  localparam int SQ_W    = 2 * DMAG_W;
  localparam int SSQ_W   = 51;
  localparam int DIV_W   = 64;
  localparam int DVS_W   = 32;
  localparam int STEP_W  = 7;
  localparam int INV_W   = 33;
  localparam int PROD_W  = DMAG_W + INV_W;
  localparam int NQ_W    = 41;
  localparam int NM_W    = 32;
  localparam int PM_W    = NM_W + DATA_W + 1;

  localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(SSQ_W);
  localparam logic [STEP_W-1:0] INV_STEPS  = STEP_W'(49);
  localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(NQ_W);

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] scale;
    logic signed [DATA_W-1:0] shift;
    logic                     row_end;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] normalized;
    logic                     final_of_row;
  } out_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic cube_a;
    logic cube_b;
    logic d_latch;
    logic sq_mul;
    logic sq_acc;
    logic var_div;
    logic var_latch;
    logic sqrt_start;
    logic inv_div;
    logic inv_latch;
    logic em_mul;
    logic em_div;
    logic norm_latch;
    logic em_scale;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

@@ rtl/lnr_ram.sv @@
`timescale 1ns / 1ps
module lnr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lnr_div.sv @@
`timescale 1ns / 1ps
module lnr_div import lnr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quotient_o
);

  // restoring divider, one quotient bit per cycle, dividend left aligned
  logic [DIV_W-1:0]  dvd_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/lnr_dp.sv @@
`timescale 1ns / 1ps
module lnr_dp import lnr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_data_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  logic [CNT_W-1:0]         cnt_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]         n_q;
  logic signed [SUM_W-1:0]  s_q;
  logic [ADDR_W-1:0]        idx_q;
  logic [2*CNT_W-1:0]       nn_q;
  logic [3*CNT_W-1:0]       cube_q;
  logic                     dneg_q;
  logic [DMAG_W-1:0]        dmag_q;
  logic [SQ_W-1:0]          sq_q;
  logic [SSQ_W-1:0]         ssq_q;
  logic [31:0]              v_q;
  logic [INV_W-1:0]         inv_q;
  logic [PROD_W-1:0]        prod_q;
  logic [NM_W-1:0]          nm_q;
  logic [PM_W-1:0]          pm_q;
  out_t                     out_q;

  logic [63:0] sx_q, sres_q, sbit_q;
  logic        sbusy_q, sdone_q;
  logic [63:0] strial;

  logic                     full;
  logic [CNT_W-1:0]         cnt_next;
  logic signed [SUM_W-1:0]  sum_next;
  logic [DATA_W-1:0]        smp_rd, scl_rd, sft_rd;
  logic signed [DIFF_W-1:0] nx, diff;
  logic [PROD_W:0]          rnd_sum;
  logic [NQ_W-1:0]          nq_val;
  logic                     div_start, div_done;
  logic [DIV_W-1:0]         div_dvd, div_quo;
  logic [DVS_W-1:0]         div_dvs;
  logic [STEP_W-1:0]        div_steps;
  logic [DATA_W:0]          smag;
  logic [PM_W-16:0]         rmag;
  logic signed [PM_W-13:0]  ysgn, ysum;
  logic                     yneg;
  logic [DATA_W-1:0]        ysat;

  // element load
  assign full     = cnt_q == CNT_W'(MAX_ROW);
  assign cnt_next = full ? cnt_q : cnt_q + 1'b1;
  assign sum_next = full ? sum_q : sum_q + SUM_W'(in_data_i.sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      n_q   <= CNT_W'(1);
      idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (in_data_i.row_end) begin
          n_q   <= cnt_next;
          cnt_q <= '0;
          sum_q <= '0;
        end else begin
          cnt_q <= cnt_next;
          sum_q <= sum_next;
        end
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_data_i.row_end) begin
      s_q <= sum_next;
    end
  end

  lnr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROW)) u_smp_ram (
    .clk_i, .we_i(cmd_i.load && !full), .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(in_data_i.sample), .raddr_i(idx_q), .rdata_o(smp_rd)
  );
  lnr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROW)) u_scl_ram (
    .clk_i, .we_i(cmd_i.load && !full), .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(in_data_i.scale), .raddr_i(idx_q), .rdata_o(scl_rd)
  );
  lnr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROW)) u_sft_ram (
    .clk_i, .we_i(cmd_i.load && !full), .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(in_data_i.shift), .raddr_i(idx_q), .rdata_o(sft_rd)
  );

  // n times the deviation from the mean
  assign nx   = DIFF_W'($signed({1'b0, n_q})) * DIFF_W'($signed(smp_rd));
  assign diff = nx - DIFF_W'(s_q);

  // shared divider
  assign div_start = cmd_i.var_div | cmd_i.inv_div | cmd_i.em_div;
  assign rnd_sum   = {1'b0, prod_q} + (PROD_W+1)'({n_q, 15'd0});
  assign nq_val    = rnd_sum[PROD_W:16];

  always_comb begin
    div_dvd   = {nq_val, (DIV_W-NQ_W)'(0)};
    div_dvs   = DVS_W'(n_q);
    div_steps = NORM_STEPS;
    if (cmd_i.var_div) begin
      div_dvd   = {ssq_q, (DIV_W-SSQ_W)'(0)};
      div_dvs   = DVS_W'(cube_q);
      div_steps = VAR_STEPS;
    end else if (cmd_i.inv_div) begin
      div_dvd   = {1'b1, (DIV_W-1)'(0)};
      div_dvs   = sres_q[DVS_W-1:0];
      div_steps = INV_STEPS;
    end
  end

  lnr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i(div_dvs), .steps_i(div_steps), .done_o(div_done),
    .quotient_o(div_quo)
  );

  // digit by digit square root, two radicand bits per cycle
  assign strial = sres_q + sbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      sdone_q <= 1'b0;
    end else begin
      sdone_q <= 1'b0;
      if (cmd_i.sqrt_start) begin
        sbusy_q <= 1'b1;
      end else if (sbusy_q && sbit_q == 64'd1) begin
        sbusy_q <= 1'b0;
        sdone_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sx_q   <= {v_q, 32'd0};
      sres_q <= '0;
      sbit_q <= 64'd1 << 62;
    end else if (sbusy_q) begin
      if (sx_q >= strial) begin
        sx_q   <= sx_q - strial;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // output arithmetic
  assign smag = scl_rd[DATA_W-1] ? (DATA_W+1)'(-$signed({scl_rd[DATA_W-1], scl_rd}))
                                 : {1'b0, scl_rd};
  assign rmag = (PM_W-15)'(({1'b0, pm_q} + (PM_W+1)'(32768)) >> 16);
  assign yneg = dneg_q ^ scl_rd[DATA_W-1];
  assign ysgn = yneg ? -$signed({3'b000, rmag}) : $signed({3'b000, rmag});
  assign ysum = ysgn + (PM_W-12)'($signed(sft_rd));

  always_comb begin
    if (ysum > (PM_W-12)'(32767)) begin
      ysat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (ysum < -(PM_W-12)'(32768)) begin
      ysat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      ysat = ysum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cube_a) begin
      nn_q  <= (2*CNT_W)'(n_q) * (2*CNT_W)'(n_q);
      ssq_q <= '0;
    end
    if (cmd_i.cube_b) begin
      cube_q <= (3*CNT_W)'(nn_q) * (3*CNT_W)'(n_q);
    end
    if (cmd_i.d_latch) begin
      dneg_q <= diff[DIFF_W-1];
      dmag_q <= diff[DIFF_W-1] ? DMAG_W'(-diff) : DMAG_W'(diff);
    end
    if (cmd_i.sq_mul) begin
      sq_q <= SQ_W'(dmag_q) * SQ_W'(dmag_q);
    end
    if (cmd_i.sq_acc) begin
      ssq_q <= ssq_q + SSQ_W'(sq_q);
    end
    if (cmd_i.var_latch) begin
      v_q <= div_quo[31:0] + 32'd1;
    end
    if (cmd_i.inv_latch) begin
      inv_q <= div_quo[INV_W-1:0];
    end
    if (cmd_i.em_mul) begin
      prod_q <= PROD_W'(dmag_q) * PROD_W'(inv_q);
    end
    if (cmd_i.norm_latch) begin
      nm_q <= (|div_quo[NQ_W-1:NM_W]) ? '1 : div_quo[NM_W-1:0];
    end
    if (cmd_i.em_scale) begin
      pm_q <= PM_W'(nm_q) * PM_W'(smag);
    end
    if (cmd_i.out_load) begin
      out_q.normalized   <= ysat;
      out_q.final_of_row <= sts_o.idx_last;
    end
  end

  assign sts_o.idx_last  = idx_q == ADDR_W'(n_q - 1'b1);
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sdone_q;
  assign out_data_o      = out_q;

endmodule

@@ rtl/lnr_ctrl.sv @@
`timescale 1ns / 1ps
module lnr_ctrl import lnr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_row_end_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_LOAD, S_CUBE_A, S_CUBE_B, S_SQ_RD, S_SQ_D, S_SQ_MUL, S_SQ_ACC,
    S_VAR_DIV, S_VAR_WAIT, S_SQRT, S_SQRT_WAIT, S_INV_DIV, S_INV_WAIT,
    S_EM_RD, S_EM_D, S_EM_MUL, S_EM_DIV, S_EM_WAIT, S_EM_SC, S_EM_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_row_end_i) begin
            state_d = S_CUBE_A;
          end
        end
      end
      S_CUBE_A: begin
        cmd_o.cube_a  = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d       = S_CUBE_B;
      end
      S_CUBE_B: begin
        cmd_o.cube_b = 1'b1;
        state_d      = S_SQ_RD;
      end
      S_SQ_RD: state_d = S_SQ_D;
      S_SQ_D: begin
        cmd_o.d_latch = 1'b1;
        state_d       = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd_o.sq_acc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_VAR_DIV;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SQ_RD;
        end
      end
      S_VAR_DIV: begin
        cmd_o.var_div = 1'b1;
        state_d       = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.var_latch = 1'b1;
          state_d         = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sts_i.sqrt_done) begin
          state_d = S_INV_DIV;
        end
      end
      S_INV_DIV: begin
        cmd_o.inv_div = 1'b1;
        state_d       = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.inv_latch = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          state_d         = S_EM_RD;
        end
      end
      S_EM_RD: state_d = S_EM_D;
      S_EM_D: begin
        cmd_o.d_latch = 1'b1;
        state_d       = S_EM_MUL;
      end
      S_EM_MUL: begin
        cmd_o.em_mul = 1'b1;
        state_d      = S_EM_DIV;
      end
      S_EM_DIV: begin
        cmd_o.em_div = 1'b1;
        state_d      = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.norm_latch = 1'b1;
          state_d          = S_EM_SC;
        end
      end
      S_EM_SC: begin
        cmd_o.em_scale = 1'b1;
        state_d        = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.idx_last) begin
            state_d = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_EM_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != S_LOAD;
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/layer_normalization_row.sv @@
`timescale 1ns / 1ps
// load: one element per cycle; the row closes on the element marked row_end
// after row end: statistics (sum of squares, 51-step divide, 32-step
// square root, 49-step divide), then one divide per result on the
// bit-serial divider; intake stays stalled until the last result of the
// row is loaded into the output register
// reset: asynchronous active low, clears control; element stores are not cleared
module layer_normalization_row import lnr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // controller issues one command per step, datapath reports loop and unit status
  cmd_t cmd;
  sts_t sts;

  // controller: load phase, statistics phase, emit phase
  lnr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_row_end_i(in_data_i.row_end),
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  // datapath: element stores, running sum, shared divider, square root,
  // per-element normalize, scale, shift and saturate into the output register
  lnr_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i(cmd),
    .in_data_i,
    .sts_o(sts),
    .out_data_o
  );

`ifndef SYNTH
  // a transaction that closes a row stops intake until the row is emitted
  a_row_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.row_end |=> in_stall_o)
    else $error("intake open after row end");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("pending result overwritten");

  // divider and square root never finish in the same cycle
  a_units_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts.div_done && sts.sqrt_done))
    else $error("divider and root done together");
`endif

endmodule

@@ sim/ln_row_checker.sv @@
`timescale 1ns / 1ps
module ln_row_checker import lnr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   errors_o,
  output int   pending_o,
  output int   results_o
);

  logic signed [DATA_W-1:0] samples_q [MAX_ROW];
  logic signed [DATA_W-1:0] gains_q   [MAX_ROW];
  logic signed [DATA_W-1:0] offsets_q [MAX_ROW];
  longint                   row_total;
  int                       row_len;
  out_t                     norm_queue [$];

  // unsigned integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // division rounded half away from zero
  function automatic longint div_round(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  task automatic close_row();
    longint          dev, y, nrm;
    longint unsigned sumsq, var_q, root, inv_std;
    out_t            res;
    sumsq = 0;
    for (int i = 0; i < row_len; i++) begin
      dev   = longint'(row_len) * longint'(samples_q[i]) - row_total;
      sumsq += longint'(dev * dev);
    end
    var_q   = sumsq / (row_len * row_len * row_len) + 1;
    root    = int_sqrt(var_q << 32);
    inv_std = (64'd1 << 48) / root;
    for (int i = 0; i < row_len; i++) begin
      dev = longint'(row_len) * longint'(samples_q[i]) - row_total;
      nrm = div_round(dev * longint'(inv_std), longint'(row_len) << 16);
      y   = div_round(nrm * longint'(gains_q[i]), 65536) + longint'(offsets_q[i]);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      res.normalized   = DATA_W'(y);
      res.final_of_row = (i == row_len - 1);
      norm_queue = {norm_queue, res};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_res;
    if (!rst_ni) begin
      row_total = 0;
      row_len   = 0;
      errors_o  = 0;
      results_o = 0;
      norm_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (norm_queue.size() == 0) begin
          $error("unexpected result transaction: normalized %0d", out_data_i.normalized);
          errors_o++;
        end else begin
          exp_res = norm_queue.pop_front();
          if (out_data_i.normalized !== exp_res.normalized) begin
            $error("normalized: expected %0d, actual %0d",
                   exp_res.normalized, out_data_i.normalized);
            errors_o++;
          end
          if (out_data_i.final_of_row !== exp_res.final_of_row) begin
            $error("final_of_row: expected %0b, actual %0b",
                   exp_res.final_of_row, out_data_i.final_of_row);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (row_len < MAX_ROW) begin
          samples_q[row_len] = in_data_i.sample;
          gains_q[row_len]   = in_data_i.scale;
          offsets_q[row_len] = in_data_i.shift;
          row_total += longint'(in_data_i.sample);
          row_len++;
        end
        if (in_data_i.row_end) begin
          if (row_len > 0) close_row();
          row_total = 0;
          row_len   = 0;
        end
      end
    end
  end

  assign pending_o = norm_queue.size();

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import lnr_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t  in_data;
  out_t out_data;
  int   errors, pending, results;
  int   rows_sent, items_sent, idle_cycles;
  logic quiet;
  logic [4:0] stall_burst;

  layer_normalization_row i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ln_row_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stall bursts, none once quiet
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_burst <= '0;
    end else if (quiet) begin
      out_stall   <= 1'b0;
      stall_burst <= '0;
    end else if (stall_burst != 0) begin
      stall_burst <= stall_burst - 5'd1;
      out_stall   <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_burst <= 5'($urandom_range(0, 17));
      out_stall   <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one element transaction; valid stays high into the next call
  task automatic send_element(logic signed [DATA_W-1:0] smp, logic signed [DATA_W-1:0] gain,
                              logic signed [DATA_W-1:0] ofs, logic last);
    in_t item;
    item.sample  = smp;
    item.scale   = gain;
    item.shift   = ofs;
    item.row_end = last;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (last) rows_sent++;
  endtask

  // row of random content; spread picks how far samples stray from a base
  task automatic send_row(int len, int spread);
    int base;
    base = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < len; i++) begin
      send_element(DATA_W'(base + $urandom_range(0, 2 * spread) - spread),
                   DATA_W'($urandom), DATA_W'($urandom), i == len - 1);
    end
  endtask

  initial begin
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    rows_sent  = 0;
    items_sent = 0;
    rst_n      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single element row: result is the shift
    send_element(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
    // two extremes: widest variance, extreme gains, saturating shifts
    send_element(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0);
    send_element(16'sh7fff, 16'sh8000, 16'sh8000, 1'b1);
    send_element(16'sh8000, 16'sh8000, 16'sh7fff, 1'b0);
    send_element(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
    // constant row: zero variance, epsilon only
    for (int i = 0; i < 4; i++) send_element(16'sh1234, 16'sh0100, 16'sh0000, i == 3);
    // tiny spread: large gain, pushes toward saturation
    send_element(16'sh0000, 16'sh7fff, 16'sh0000, 1'b0);
    send_element(16'sh0001, 16'sh7fff, 16'sh0000, 1'b0);
    send_element(16'shffff, 16'sh8000, 16'sh0000, 1'b1);
    // mixed small row
    send_element(16'sh0100, 16'sh0100, 16'sh0080, 1'b0);
    send_element(16'shff00, 16'sh0200, 16'shff80, 1'b0);
    send_element(16'sh5555, 16'shaaaa, 16'sh5555, 1'b0);
    send_element(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b1);

    // random rows, mostly short
    while (items_sent < 20) send_row($urandom_range(1, 10), $urandom_range(0, 3) == 0 ?
                                     $urandom_range(0, 4) : $urandom_range(1, 32767));
    // row overflow: elements past the limit are ignored, row_end still closes
    send_row(MAX_ROW + 3, 20000);
    // last part without idling or stalls
    quiet = 1'b1;
    for (int r = 0; r < 4; r++) send_row($urandom_range(1, 4), $urandom_range(1, 32767));
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d rows, %0d elements, %0d results, incl. overflow and constant rows",
             rows_sent, items_sent, results);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
